### rtl/core/iafp_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the IMU angle frame parser.
// No dependencies; compile first.
package iafp_pkg;

  localparam logic [7:0] HDR_FIRST     = 8'h55;
  localparam logic [7:0] HDR_SECOND    = 8'h53;
  localparam logic [7:0] TAIL_FIRST    = 8'hFB;
  localparam logic [7:0] TAIL_SECOND   = 8'h46;
  localparam logic [7:0] MIN_FRAME     = 8'd10;
  localparam logic [7:0] MAX_FRAME_LEN = 8'd128;

  // frame bytes 2..7 hold the three angles
  localparam int ANGLE_BYTES = 6;
  localparam int ANGLE_IDX_W = 3;
  localparam logic [7:0] ANGLE_FIRST = 8'd2;
  localparam logic [7:0] ANGLE_LAST  = 8'd7;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] roll_raw;
    logic signed [15:0] pitch_raw;
    logic signed [15:0] yaw_raw;
    logic        [7:0]  frame_length;
  } iafp_result_t;

endpackage

### rtl/core/iafp_byte_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one received serial byte per word.
// No dependencies.
interface iafp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/core/iafp_angle_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one decoded angle frame per word.
// No dependencies.
interface iafp_angle_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_raw;
  logic signed [15:0] pitch_raw;
  logic signed [15:0] yaw_raw;
  logic        [7:0]  frame_length;

  modport source (output valid, output roll_raw, output pitch_raw, output yaw_raw,
                  output frame_length, input ready);
  modport sink   (input valid, input roll_raw, input pitch_raw, input yaw_raw,
                  input frame_length, output ready);
endinterface

### rtl/core/imu_angle_frame_parser.sv
`timescale 1ns / 1ps
// Top level of the IMU angle frame parser: input register, frame tracker,
// output register. Depends on iafp_pkg, iafp_byte_if, iafp_angle_if, iafp_frame_tracker.
//
//   port   dir  word contents
//   rx     in   rx_byte (8b serial byte)
//   angle  out  roll_raw, pitch_raw, yaw_raw (s16), frame_length (u8)
//
// One byte per cycle sustained while no finished result is held by a stalled output.
// Latency is set by the input register and the output register around the tracker.
// rst is synchronous: the parser returns to header hunt, both registers empty.
// A stalled result only holds back a byte that itself completes a frame; other bytes
// keep flowing while the result waits.
module imu_angle_frame_parser import iafp_pkg::*; (
  input logic         clk,
  input logic         rst,
  iafp_byte_if.sink   rx,
  iafp_angle_if.source angle
);

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         advance;
  iafp_result_t result;

  logic               out_valid;
  logic signed [15:0] out_roll;
  logic signed [15:0] out_pitch;
  logic signed [15:0] out_yaw;
  logic        [7:0]  out_len;

  iafp_frame_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .data   (s1_byte),
    .result (result)
  );

  assign advance  = s1_valid && (!result.valid || !out_valid || angle.ready);
  assign rx.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.valid) begin
      out_valid <= 1'b1;
    end else if (angle.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      out_roll  <= result.roll_raw;
      out_pitch <= result.pitch_raw;
      out_yaw   <= result.yaw_raw;
      out_len   <= result.frame_length;
    end
  end

  assign angle.valid        = out_valid;
  assign angle.roll_raw     = out_roll;
  assign angle.pitch_raw    = out_pitch;
  assign angle.yaw_raw      = out_yaw;
  assign angle.frame_length = out_len;

endmodule

### rtl/core/iafp_frame_tracker.sv
`timescale 1ns / 1ps
// Frame state: header hunt, byte count, tail detect and angle byte capture.
// Depends on iafp_pkg.
module iafp_frame_tracker import iafp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   data,
  output iafp_result_t result
);

  logic [7:0] byte_count;
  logic [7:0] byte_count_next;
  logic [7:0] previous_byte;
  logic [7:0] angle_bytes [ANGLE_BYTES];

  logic [7:0] count;
  logic       ignore;
  logic       tail;
  logic       overflow;
  logic       angle_wr;
  logic [ANGLE_IDX_W-1:0] angle_idx;
  logic [7:0] angle_off;

  assign ignore = ((byte_count == 8'd0) && (data != HDR_FIRST)) ||
                  ((byte_count == 8'd1) && (data != HDR_SECOND));
  assign count    = byte_count + 8'd1;
  assign tail     = (byte_count != 8'd0) && (previous_byte == TAIL_FIRST) &&
                    (data == TAIL_SECOND);
  assign overflow = (count >= MAX_FRAME_LEN);
  assign angle_wr = !ignore && (byte_count >= ANGLE_FIRST) && (byte_count <= ANGLE_LAST);
  assign angle_off = byte_count - ANGLE_FIRST;
  assign angle_idx = angle_off[ANGLE_IDX_W-1:0];

  always_comb begin
    if (ignore || overflow || tail) begin
      byte_count_next = 8'd0;
    end else begin
      byte_count_next = count;
    end
  end

  // the sixth angle byte lands at count 8, so no bypass from data is needed
  always_comb begin
    result.valid        = !ignore && !overflow && tail && (count >= MIN_FRAME);
    result.roll_raw     = {angle_bytes[1], angle_bytes[0]};
    result.pitch_raw    = {angle_bytes[3], angle_bytes[2]};
    result.yaw_raw      = {angle_bytes[5], angle_bytes[4]};
    result.frame_length = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= 8'd0;
      previous_byte <= 8'd0;
    end else if (step) begin
      byte_count <= byte_count_next;
      if (!ignore) begin
        previous_byte <= data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && angle_wr) begin
      angle_bytes[angle_idx] <= data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count < MAX_FRAME_LEN)
    else $error("byte count reached frame limit");

  a_result_len: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (count >= MIN_FRAME) && (count < MAX_FRAME_LEN))
    else $error("result frame length out of range");

  a_result_rearm: assert property (@(posedge clk) disable iff (rst)
    step && result.valid |=> byte_count == 8'd0)
    else $error("parser not back to hunt after frame");

  a_hunt_hold: assert property (@(posedge clk) disable iff (rst)
    step && (byte_count == 8'd0) && (data != HDR_FIRST) |=>
      (byte_count == 8'd0) && $stable(previous_byte))
    else $error("non-header byte changed hunt state");

endmodule

### tb/iafp_frame_checker.sv
`timescale 1ns / 1ps
// Watches the byte and angle channels of the IMU angle frame parser, tracks frames
// from the accepted bytes and compares each decoded angle word. Depends on iafp_pkg
// and the two channel interfaces.
module iafp_frame_checker import iafp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  iafp_byte_if  rx,
  iafp_angle_if angle,
  output int    mismatches,
  output int    outstanding
);

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic        [7:0]  len;
  } angle_word_t;

  angle_word_t pending_angles[$];

  logic [7:0] frame_count;
  logic [7:0] last_byte;
  logic [7:0] angle_buf [ANGLE_BYTES];

  // Advances the frame tracker by one byte; returns 1 when a frame decodes.
  function automatic bit track_byte(input logic [7:0] b, output angle_word_t w);
    logic [8:0] cnt;
    bit         tail;
    w = '0;
    if (frame_count == 8'd0 && b != HDR_FIRST) return 1'b0;
    if (frame_count == 8'd1 && b != HDR_SECOND) begin
      // bad second header byte is dropped, not taken as a new start
      frame_count = 8'd0;
      return 1'b0;
    end
    if (frame_count >= ANGLE_FIRST && frame_count <= ANGLE_LAST)
      angle_buf[frame_count - ANGLE_FIRST] = b;
    cnt = {1'b0, frame_count} + 9'd1;
    tail = (cnt >= 9'd2) && last_byte == TAIL_FIRST && b == TAIL_SECOND;
    last_byte = b;
    // overflow beats a tail on the same byte
    if (cnt >= {1'b0, MAX_FRAME_LEN}) begin
      frame_count = 8'd0;
      return 1'b0;
    end
    if (!tail) begin
      frame_count = cnt[7:0];
      return 1'b0;
    end
    frame_count = 8'd0;
    if (cnt < {1'b0, MIN_FRAME}) return 1'b0;
    w.roll  = {angle_buf[1], angle_buf[0]};
    w.pitch = {angle_buf[3], angle_buf[2]};
    w.yaw   = {angle_buf[5], angle_buf[4]};
    w.len   = cnt[7:0];
    return 1'b1;
  endfunction

  task automatic report(input string what, input angle_word_t want, input angle_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t: %s: exp roll %0d pitch %0d yaw %0d len %0d, ",
                "got roll %0d pitch %0d yaw %0d len %0d"},
               $time, what, want.roll, want.pitch, want.yaw, want.len,
               got.roll, got.pitch, got.yaw, got.len);
  endtask

  always @(posedge clk) begin : watch
    angle_word_t got;
    angle_word_t want;
    if (rst) begin
      frame_count = 8'd0;
      last_byte   = 8'd0;
      pending_angles.delete();
    end else begin
      // output side first: a word leaving now never belongs to a byte entering now
      if (angle.valid && angle.ready) begin
        got.roll  = angle.roll_raw;
        got.pitch = angle.pitch_raw;
        got.yaw   = angle.yaw_raw;
        got.len   = angle.frame_length;
        if (pending_angles.size() == 0) begin
          report("unexpected angle word", '0, got);
        end else begin
          want = pending_angles.pop_front();
          if (got.roll != want.roll || got.pitch != want.pitch ||
              got.yaw != want.yaw || got.len != want.len)
            report("angle word mismatch", want, got);
        end
      end
      if (rx.valid && rx.ready && track_byte(rx.rx_byte, want))
        pending_angles.push_back(want);
    end
    outstanding = pending_angles.size();
  end

endmodule

### tb/imu_angle_frame_parser_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the IMU angle frame parser: feeds frames, broken headers
// and line noise, stalls the result side. Depends on iafp_pkg, the channel
// interfaces, imu_angle_frame_parser and iafp_frame_checker.
module imu_angle_frame_parser_tb;
  import iafp_pkg::*;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   src_idle_pct;
  int   sink_idle_pct;
  logic hold_off_req;

  iafp_byte_if  rx_ch();
  iafp_angle_if angle_ch();

  imu_angle_frame_parser dut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_ch),
    .angle (angle_ch)
  );

  iafp_frame_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx_ch),
    .angle       (angle_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls plus one long hold-off when asked
  initial begin : sink_side
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    angle_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        angle_ch.ready <= 1'b0;
      end else begin
        angle_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
  endtask

  // header, len-4 body bytes, tail; extreme picks boundary angle bytes
  task automatic send_frame(input int len, input bit extreme);
    logic [7:0] b;
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    for (int i = 0; i < len - 4; i++) begin
      if (extreme) begin
        case ($urandom_range(0, 3))
          0:       b = 8'h00;
          1:       b = 8'h80;
          2:       b = 8'h7F;
          default: b = 8'hFF;
        endcase
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      send_byte(b);
    end
    send_byte(TAIL_FIRST);
    send_byte(TAIL_SECOND);
  endtask

  task automatic send_noise(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == HDR_FIRST) b = ~b;
      send_byte(b);
    end
  endtask

  task automatic drain();
    rx_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int         sent;
    int         iter;
    int         kind;
    int         n;
    logic [7:0] b;
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    hold_off_req  <= 1'b0;
    src_idle_pct  = 33;
    sink_idle_pct = 33;
    sent          = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: hunt noise, bad second header byte that is not a restart,
    // tail right after the header, minimum frame with extreme angles
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(TAIL_FIRST);
    send_byte(TAIL_SECOND);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(TAIL_FIRST);
    send_byte(TAIL_SECOND);
    sent = 19;

    iter = 0;
    while (sent < 850 || iter < 23) begin
      iter++;
      if (iter == 6) begin
        // long receiver hold-off while frames keep coming: block must back up
        hold_off_req <= 1'b1;
        src_idle_pct = 0;
        for (int i = 0; i < 12; i++) send_frame(10, 1'b0);
        src_idle_pct = 33;
        sent += 120;
      end else if (iter == 10) begin
        send_frame(127, 1'b0);
        sent += 127;
      end else if (iter == 11) begin
        drain();
      end else if (iter == 12) begin
        // tail lands on the overflow byte: frame is dropped
        send_frame(128, 1'b0);
        sent += 128;
      end else if (iter >= 13 && iter < 23) begin
        if (iter == 13) begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
        n = $urandom_range(10, 16);
        send_frame(n, 1'b0);
        sent += n;
        if (iter == 22) begin
          src_idle_pct = 33;
          sink_idle_pct = 33;
        end
      end else if (iter == 23) begin
        // runaway frame with no tail overflows and falls back to hunting
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        for (int i = 0; i < 140; i++) begin
          b = 8'($urandom_range(0, 255));
          if (b == TAIL_SECOND) b = 8'h00;
          send_byte(b);
        end
        sent += 142;
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          n = $urandom_range(10, 24);
          send_frame(n, 1'b0);
          sent += n;
        end else if (kind < 62) begin
          send_frame(10, 1'b1);
          sent += 10;
        end else if (kind < 70) begin
          n = $urandom_range(1, 5);
          send_noise(n);
          sent += n;
        end else if (kind < 78) begin
          b = 8'($urandom_range(0, 255));
          if (b == HDR_SECOND) b = HDR_FIRST;
          send_byte(HDR_FIRST);
          send_byte(b);
          send_byte(HDR_SECOND);
          sent += 3;
        end else if (kind < 86) begin
          n = $urandom_range(4, 9);
          send_frame(n, 1'b0);
          sent += n;
        end else if (kind < 92) begin
          // cut-off frame: following bytes are absorbed into it
          n = $urandom_range(1, 8);
          send_byte(HDR_FIRST);
          send_byte(HDR_SECOND);
          for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
          sent += n + 2;
        end else begin
          n = $urandom_range(25, 60);
          send_frame(n, 1'b0);
          sent += n;
        end
      end
    end

    rx_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
